@@ rtl/mcrb_pkg.sv @@
package mcrb_pkg;

   // Default sizing of the block.
   localparam int CHANNELS_DEF      = 4;
   localparam int CHANNEL_DEPTH_DEF = 1024;
   localparam int MAX_BURST_DEF     = 64;

   // Field widths fixed by the word formats.
   localparam int ACTION_W   = 3;
   localparam int CHANNEL_W  = 2;
   localparam int DATA_W     = 8;
   localparam int COUNT_W    = 7;
   localparam int POS_W      = 10;
   localparam int STATUS_W   = 2;
   localparam int CIU_W      = 3;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 11;

   // Every value of the channel field has its own pointer pair and size register.
   localparam int NUM_SLOTS = 2 ** CHANNEL_W;

   localparam logic [CFG_DATA_W-1:0] CAP_RESET = CFG_DATA_W'(1024);

   // Register indexes of the configuration port.
   localparam logic [CFG_IDX_W-1:0] CSR_CHANNELS_IN_USE = CFG_IDX_W'(0);
   localparam logic [CFG_IDX_W-1:0] CSR_CAPACITY_FIRST  = CFG_IDX_W'(1);
   localparam logic [CFG_IDX_W-1:0] CSR_CAPACITY_LAST   = CFG_IDX_W'(NUM_SLOTS);

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE  = 3'd0,
      ACT_READ   = 3'd1,
      ACT_CLEAR  = 3'd2,
      ACT_STATUS = 3'd3,
      ACT_SET    = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ENG_INIT,
      ENG_IDLE,
      ENG_EVAL,
      ENG_EXEC,
      ENG_BURST,
      ENG_CLEAR,
      ENG_FINISH
   } engine_state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [CHANNEL_W-1:0] channel;
      logic [DATA_W-1:0]    data_in;
      logic                 overwrite;
      logic [COUNT_W-1:0]   read_count;
      logic [POS_W-1:0]     new_write_position;
      logic [POS_W-1:0]     new_read_position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   read_data;
      logic                data_valid;
      logic                last;
      logic [POS_W-1:0]    fill_count;
      logic [POS_W-1:0]    free_space;
      logic [POS_W-1:0]    write_position;
      logic [POS_W-1:0]    read_position;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/multi_channel_byte_ring_buffer.sv @@
// Multi-channel byte ring buffer: up to four byte rings that share one byte store.
//
// Words enter on the req_ channel (req_valid, req_stall, req_data) and name a
// channel and an action: write a byte, read a burst, clear, query or set pointers.
// Results leave on the rsp_ channel; every word yields one result word, except a
// read burst that finds bytes: one word per byte delivered, the final one marked last.
// Ring sizes and the number of channels in use are set over the csr_ write port
// while the block is idle, a rule for the user that the block itself does not enforce.
//
// Timing: a word that yields one result passes the engine states IDLE, EVAL and
// EXEC, and the engine takes the next word only back in IDLE. A read burst streams
// one byte a cycle out of the registered store read while rsp_stall is low. A clear
// zeroes the ring's store entries, one per cycle, and then yields its result word.
// A two-entry queue lets the front take words while the engine works.
//
// Reset: pointers go to zero, no channel is in use and every size reads 1024. The
// engine then zeroes the whole store, one entry per cycle (CHANNELS * CHANNEL_DEPTH
// entries, 4096 by default); req_stall stays high meanwhile, csr_ writes are taken.
// When the receiver holds rsp_stall, the result register holds its word and the
// engine waits; the queue fills and then req_stall rises.
module multi_channel_byte_ring_buffer #(
   parameter int CHANNELS      = mcrb_pkg::CHANNELS_DEF,
   parameter int CHANNEL_DEPTH = mcrb_pkg::CHANNEL_DEPTH_DEF,
   parameter int MAX_BURST     = mcrb_pkg::MAX_BURST_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mcrb_pkg::CFG_IDX_W-1:0]  csr_index,
   input  logic [mcrb_pkg::CFG_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mcrb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mcrb_pkg::rsp_type               rsp_data
);

   localparam int SW     = $clog2(CHANNEL_DEPTH + 1);
   localparam int MEM_AW = $clog2(CHANNELS * CHANNEL_DEPTH);
   localparam int RQ_W   = $bits(mcrb_pkg::req_type);
   localparam int QW     = RQ_W + 1 + SW + MEM_AW;

   mcrb_pkg::queue_status_type q_status;
   logic                       init_busy;
   logic                       push, pop;
   mcrb_pkg::req_type          push_req, head_req;
   logic                       push_bad, head_bad;
   logic [SW-1:0]              push_size, head_size;
   logic [MEM_AW-1:0]          push_base, head_base;
   logic [QW-1:0]              q_wdata, q_rdata;

   // The front checks the channel and works out the ring size and store region.
   mcrb_front #(
      .CHANNELS      (CHANNELS),
      .CHANNEL_DEPTH (CHANNEL_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .init_busy (init_busy),
      .push      (push),
      .push_req  (push_req),
      .push_bad  (push_bad),
      .push_size (push_size),
      .push_base (push_base)
   );

   assign q_wdata = {push_req, push_bad, push_size, push_base};

   mcrb_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (q_wdata),
      .pop    (pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   assign {head_req, head_bad, head_size, head_base} = q_rdata;

   // The engine owns the pointers and the store and produces the result words.
   mcrb_engine #(
      .CHANNELS      (CHANNELS),
      .CHANNEL_DEPTH (CHANNEL_DEPTH),
      .MAX_BURST     (MAX_BURST)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_req  (head_req),
      .head_bad  (head_bad),
      .head_size (head_size),
      .head_base (head_base),
      .pop       (pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/mcrb_ram.sv @@
module mcrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/mcrb_front.sv @@
module mcrb_front #(
   parameter int CHANNELS      = mcrb_pkg::CHANNELS_DEF,
   parameter int CHANNEL_DEPTH = mcrb_pkg::CHANNEL_DEPTH_DEF,
   localparam int SW     = $clog2(CHANNEL_DEPTH + 1),
   localparam int MEM_AW = $clog2(CHANNELS * CHANNEL_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mcrb_pkg::CFG_IDX_W-1:0]   csr_index,
   input  logic [mcrb_pkg::CFG_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  mcrb_pkg::req_type                req_data,
   input  mcrb_pkg::queue_status_type       q_status,
   input  logic                             init_busy,
   output logic                             push,
   output mcrb_pkg::req_type                push_req,
   output logic                             push_bad,
   output logic [SW-1:0]                    push_size,
   output logic [MEM_AW-1:0]                push_base
);

   localparam int CMP_W  = (SW > mcrb_pkg::CFG_DATA_W) ? SW : mcrb_pkg::CFG_DATA_W;
   localparam int SLOT_W = mcrb_pkg::CHANNEL_W;

   logic [mcrb_pkg::CIU_W-1:0]      ciu_ff, ciu_in;
   logic [mcrb_pkg::CFG_DATA_W-1:0] cap_ff [mcrb_pkg::NUM_SLOTS];
   logic [mcrb_pkg::CFG_DATA_W-1:0] cap_in [mcrb_pkg::NUM_SLOTS];
   logic [mcrb_pkg::CFG_IDX_W-1:0]  cap_idx;
   logic [CMP_W-1:0]                cap_ext;

   assign cap_idx = csr_index - mcrb_pkg::CSR_CAPACITY_FIRST;

   always_comb begin
      ciu_in = ciu_ff;
      cap_in = cap_ff;
      if (csr_we) begin
         if (csr_index == mcrb_pkg::CSR_CHANNELS_IN_USE) begin
            ciu_in = csr_wdata[mcrb_pkg::CIU_W-1:0];
         end else if (csr_index inside {[mcrb_pkg::CSR_CAPACITY_FIRST :
                                         mcrb_pkg::CSR_CAPACITY_LAST]}) begin
            cap_in[cap_idx[SLOT_W-1:0]] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ciu_ff <= '0;
         for (int i = 0; i < mcrb_pkg::NUM_SLOTS; i++) begin
            cap_ff[i] <= mcrb_pkg::CAP_RESET;
         end
      end else begin
         ciu_ff <= ciu_in;
         cap_ff <= cap_in;
      end
   end

   // Words are held off while the store is being cleared after reset.
   assign req_stall = q_status.full || init_busy;
   assign push      = req_valid && !req_stall;
   assign push_req  = req_data;

   // A channel is refused when it is not registered or not built.
   assign push_bad = (mcrb_pkg::CIU_W'(req_data.channel) >= ciu_ff) ||
                     (32'(req_data.channel) >= 32'(CHANNELS));

   // The ring size in use is the size register held between two and the built depth.
   assign cap_ext = CMP_W'(cap_ff[req_data.channel]);

   always_comb begin
      if (cap_ext < CMP_W'(2)) begin
         push_size = SW'(2);
      end else if (cap_ext > CMP_W'(CHANNEL_DEPTH)) begin
         push_size = SW'(CHANNEL_DEPTH);
      end else begin
         push_size = SW'(cap_ext);
      end
   end

   assign push_base = MEM_AW'(req_data.channel) * MEM_AW'(CHANNEL_DEPTH);

endmodule

@@ rtl/mcrb_queue.sv @@
module mcrb_queue #(
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output mcrb_pkg::queue_status_type status
);

   logic [WIDTH-1:0]              data_ff [mcrb_pkg::QUEUE_DEPTH];
   logic [mcrb_pkg::QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [mcrb_pkg::QCNT_W-1:0]   count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mcrb_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mcrb_pkg::QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + mcrb_pkg::QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - mcrb_pkg::QCNT_W'(1);
         end
      end
   end

   assign rdata        = data_ff[rd_ptr_ff];
   assign status.full  = (count_ff == mcrb_pkg::QCNT_W'(mcrb_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

@@ rtl/mcrb_engine.sv @@
module mcrb_engine #(
   parameter int CHANNELS      = mcrb_pkg::CHANNELS_DEF,
   parameter int CHANNEL_DEPTH = mcrb_pkg::CHANNEL_DEPTH_DEF,
   parameter int MAX_BURST     = mcrb_pkg::MAX_BURST_DEF,
   localparam int SW     = $clog2(CHANNEL_DEPTH + 1),
   localparam int MEM_AW = $clog2(CHANNELS * CHANNEL_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mcrb_pkg::queue_status_type q_status,
   input  mcrb_pkg::req_type          head_req,
   input  logic                       head_bad,
   input  logic [SW-1:0]              head_size,
   input  logic [MEM_AW-1:0]          head_base,
   output logic                       pop,
   output logic                       init_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mcrb_pkg::rsp_type          rsp_data
);

   localparam int TOTAL = CHANNELS * CHANNEL_DEPTH;
   localparam int PW    = $clog2(CHANNEL_DEPTH);
   localparam int BW    = $clog2(MAX_BURST + 1);
   localparam int XW    = (SW > mcrb_pkg::POS_W) ? SW : mcrb_pkg::POS_W;
   localparam int CBW   = (BW > mcrb_pkg::COUNT_W) ? BW : mcrb_pkg::COUNT_W;
   localparam int NW    = (BW > SW) ? BW : SW;

   function automatic logic [SW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r,
                                             input logic [SW-1:0] s);
      fill_of = (w >= r) ? (SW'(w) - SW'(r)) : (s - SW'(r) + SW'(w));
   endfunction

   function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p, input logic [SW-1:0] s);
      ring_inc = ((SW'(p) + SW'(1)) >= s) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] clamp_ptr(input logic [PW-1:0] p, input logic [SW-1:0] s);
      clamp_ptr = (SW'(p) > (s - SW'(1))) ? PW'(s - SW'(1)) : p;
   endfunction

   function automatic logic [PW-1:0] clamp_pos(input logic [mcrb_pkg::POS_W-1:0] v,
                                               input logic [SW-1:0] s);
      clamp_pos = (XW'(v) > XW'(s - SW'(1))) ? PW'(s - SW'(1)) : PW'(v);
   endfunction

   mcrb_pkg::engine_state_type state_ff, state_in;

   mcrb_pkg::req_type   item_ff, item_in;
   logic                bad_ff, bad_in;
   logic [SW-1:0]       size_ff, size_in;
   logic [MEM_AW-1:0]   base_ff, base_in;

   logic [PW-1:0]       cur_w_ff, cur_w_in, cur_r_ff, cur_r_in;
   logic [PW-1:0]       ip_ff, ip_in;
   logic [PW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [BW-1:0]       issue_left_ff, issue_left_in, cons_left_ff, cons_left_in;
   logic                have_ff, have_in;
   logic [MEM_AW-1:0]   init_addr_ff, init_addr_in;

   logic [PW-1:0]       w_arr_ff [mcrb_pkg::NUM_SLOTS];
   logic [PW-1:0]       r_arr_ff [mcrb_pkg::NUM_SLOTS];
   logic                arr_we;
   logic [PW-1:0]       arr_w_in, arr_r_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   mcrb_pkg::status_type        o_status_ff;
   logic [mcrb_pkg::DATA_W-1:0] o_data_ff;
   logic                        o_dvalid_ff, o_last_ff;
   logic [PW-1:0]               o_w_ff, o_r_ff;
   logic [SW-1:0]               o_size_ff;
   logic [SW-1:0]               o_fill;

   logic                        emit;
   mcrb_pkg::status_type        e_status;
   logic [mcrb_pkg::DATA_W-1:0] e_data;
   logic                        e_dvalid, e_last;
   logic [PW-1:0]               e_w, e_r;
   logic [SW-1:0]               e_size;

   logic                        mem_we, mem_re;
   logic [MEM_AW-1:0]           mem_waddr, mem_raddr;
   logic [mcrb_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

   logic                        out_free;
   logic [SW-1:0]               fill;
   logic                        full;
   logic [BW-1:0]               cnt_c, burst_n;
   logic                        consume, issue;

   mcrb_ram #(
      .WIDTH (mcrb_pkg::DATA_W),
      .DEPTH (TOTAL)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fill     = fill_of(cur_w_ff, cur_r_ff, size_ff);
   assign full     = (fill == (size_ff - SW'(1)));
   assign cnt_c    = (CBW'(item_ff.read_count) > CBW'(MAX_BURST)) ?
                     BW'(MAX_BURST) : BW'(item_ff.read_count);
   assign burst_n  = (NW'(cnt_c) < NW'(fill)) ? cnt_c : BW'(fill);
   assign consume  = have_ff && out_free;
   assign issue    = (issue_left_ff != '0) && (!have_ff || consume);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      bad_in        = bad_ff;
      size_in       = size_ff;
      base_in       = base_ff;
      cur_w_in      = cur_w_ff;
      cur_r_in      = cur_r_ff;
      ip_in         = ip_ff;
      clr_ptr_in    = clr_ptr_ff;
      issue_left_in = issue_left_ff;
      cons_left_in  = cons_left_ff;
      have_in       = have_ff;
      init_addr_in  = init_addr_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = base_ff + MEM_AW'(cur_w_ff);
      mem_wdata     = item_ff.data_in;
      mem_re        = 1'b0;
      mem_raddr     = base_ff + MEM_AW'(ip_ff);
      arr_we        = 1'b0;
      arr_w_in      = cur_w_ff;
      arr_r_in      = cur_r_ff;
      emit          = 1'b0;
      e_status      = mcrb_pkg::ST_OK;
      e_data        = '0;
      e_dvalid      = 1'b0;
      e_last        = 1'b1;
      e_w           = cur_w_ff;
      e_r           = cur_r_ff;
      e_size        = size_ff;

      case (state_ff)
         mcrb_pkg::ENG_INIT: begin
            mem_we       = 1'b1;
            mem_waddr    = init_addr_ff;
            mem_wdata    = '0;
            init_addr_in = init_addr_ff + MEM_AW'(1);
            if (init_addr_ff == MEM_AW'(TOTAL - 1)) begin
               state_in = mcrb_pkg::ENG_IDLE;
            end
         end
         mcrb_pkg::ENG_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               item_in  = head_req;
               bad_in   = head_bad;
               size_in  = head_size;
               base_in  = head_base;
               state_in = mcrb_pkg::ENG_EVAL;
            end
         end
         mcrb_pkg::ENG_EVAL: begin
            // Pointers left beyond a shrunken ring are pulled back to its end.
            cur_w_in = clamp_ptr(w_arr_ff[item_ff.channel], size_ff);
            cur_r_in = clamp_ptr(r_arr_ff[item_ff.channel], size_ff);
            state_in = mcrb_pkg::ENG_EXEC;
         end
         mcrb_pkg::ENG_EXEC: begin
            if (bad_ff) begin
               e_status = mcrb_pkg::ST_BAD;
               e_w      = '0;
               e_r      = '0;
               e_size   = SW'(1);
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = mcrb_pkg::ENG_IDLE;
               end
            end else begin
               case (mcrb_pkg::action_type'(item_ff.action))
                  mcrb_pkg::ACT_WRITE: begin
                     if (full && !item_ff.overwrite) begin
                        e_status = mcrb_pkg::ST_FULL;
                     end else begin
                        e_w = ring_inc(cur_w_ff, size_ff);
                        e_r = full ? ring_inc(cur_r_ff, size_ff) : cur_r_ff;
                     end
                     if (out_free) begin
                        emit     = 1'b1;
                        mem_we   = !(full && !item_ff.overwrite);
                        arr_we   = 1'b1;
                        arr_w_in = e_w;
                        arr_r_in = e_r;
                        state_in = mcrb_pkg::ENG_IDLE;
                     end
                  end
                  mcrb_pkg::ACT_READ: begin
                     if (fill == '0 || burst_n == '0) begin
                        e_status = (fill == '0) ? mcrb_pkg::ST_EMPTY : mcrb_pkg::ST_OK;
                        if (out_free) begin
                           emit     = 1'b1;
                           arr_we   = 1'b1;
                           state_in = mcrb_pkg::ENG_IDLE;
                        end
                     end else begin
                        ip_in         = cur_r_ff;
                        issue_left_in = burst_n;
                        cons_left_in  = burst_n;
                        have_in       = 1'b0;
                        state_in      = mcrb_pkg::ENG_BURST;
                     end
                  end
                  mcrb_pkg::ACT_CLEAR: begin
                     cur_w_in   = '0;
                     cur_r_in   = '0;
                     clr_ptr_in = '0;
                     state_in   = mcrb_pkg::ENG_CLEAR;
                  end
                  mcrb_pkg::ACT_SET: begin
                     e_w = clamp_pos(item_ff.new_write_position, size_ff);
                     e_r = clamp_pos(item_ff.new_read_position, size_ff);
                     if (out_free) begin
                        emit     = 1'b1;
                        arr_we   = 1'b1;
                        arr_w_in = e_w;
                        arr_r_in = e_r;
                        state_in = mcrb_pkg::ENG_IDLE;
                     end
                  end
                  default: begin
                     // Status query; the unassigned codes behave the same way.
                     if (out_free) begin
                        emit     = 1'b1;
                        arr_we   = 1'b1;
                        state_in = mcrb_pkg::ENG_IDLE;
                     end
                  end
               endcase
            end
         end
         mcrb_pkg::ENG_BURST: begin
            // One read is kept in flight ahead of the output register.
            mem_re   = issue;
            e_data   = mem_rdata;
            e_dvalid = 1'b1;
            e_last   = (cons_left_ff == BW'(1));
            e_r      = ring_inc(cur_r_ff, size_ff);
            if (issue) begin
               ip_in         = ring_inc(ip_ff, size_ff);
               issue_left_in = issue_left_ff - BW'(1);
            end
            have_in = issue || (have_ff && !consume);
            if (consume) begin
               emit         = 1'b1;
               cur_r_in     = e_r;
               cons_left_in = cons_left_ff - BW'(1);
               if (e_last) begin
                  arr_we   = 1'b1;
                  arr_r_in = e_r;
                  state_in = mcrb_pkg::ENG_IDLE;
               end
            end
         end
         mcrb_pkg::ENG_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = base_ff + MEM_AW'(clr_ptr_ff);
            mem_wdata  = '0;
            clr_ptr_in = clr_ptr_ff + PW'(1);
            if (SW'(clr_ptr_ff) == (size_ff - SW'(1))) begin
               state_in = mcrb_pkg::ENG_FINISH;
            end
         end
         mcrb_pkg::ENG_FINISH: begin
            if (out_free) begin
               emit     = 1'b1;
               arr_we   = 1'b1;
               state_in = mcrb_pkg::ENG_IDLE;
            end
         end
         default: begin
            state_in = mcrb_pkg::ENG_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mcrb_pkg::ENG_INIT;
         init_addr_ff  <= '0;
         have_ff       <= 1'b0;
         issue_left_ff <= '0;
         cons_left_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < mcrb_pkg::NUM_SLOTS; i++) begin
            w_arr_ff[i] <= '0;
            r_arr_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         have_ff       <= have_in;
         issue_left_ff <= issue_left_in;
         cons_left_ff  <= cons_left_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (arr_we) begin
            w_arr_ff[item_ff.channel] <= arr_w_in;
            r_arr_ff[item_ff.channel] <= arr_r_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      bad_ff     <= bad_in;
      size_ff    <= size_in;
      base_ff    <= base_in;
      cur_w_ff   <= cur_w_in;
      cur_r_ff   <= cur_r_in;
      ip_ff      <= ip_in;
      clr_ptr_ff <= clr_ptr_in;
      if (emit) begin
         o_status_ff <= e_status;
         o_data_ff   <= e_data;
         o_dvalid_ff <= e_dvalid;
         o_last_ff   <= e_last;
         o_w_ff      <= e_w;
         o_r_ff      <= e_r;
         o_size_ff   <= e_size;
      end
   end

   // A refused channel is stored with a ring size of one so that fill and free read zero.
   assign o_fill    = fill_of(o_w_ff, o_r_ff, o_size_ff);
   assign init_busy = (state_ff == mcrb_pkg::ENG_INIT);
   assign rsp_valid = rsp_valid_ff;

   assign rsp_data.status         = o_status_ff;
   assign rsp_data.read_data      = o_data_ff;
   assign rsp_data.data_valid     = o_dvalid_ff;
   assign rsp_data.last           = o_last_ff;
   assign rsp_data.fill_count     = mcrb_pkg::POS_W'(o_fill);
   assign rsp_data.free_space     = mcrb_pkg::POS_W'(o_size_ff - SW'(1) - o_fill);
   assign rsp_data.write_position = mcrb_pkg::POS_W'(o_w_ff);
   assign rsp_data.read_position  = mcrb_pkg::POS_W'(o_r_ff);

endmodule

@@ rtl/mcrb_checker.sv @@
module mcrb_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mcrb_pkg::rsp_type rsp_data
);

   // A stalled result word stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Only a delivered byte may leave a result open; every other word ends its item and carries no byte.
   a_nodata_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.data_valid |-> rsp_data.last && (rsp_data.read_data == '0))
      else $error("word without data is not final or carries a byte");

   // A delivered byte always comes with an ok status.
   a_data_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid |-> (rsp_data.status == mcrb_pkg::ST_OK))
      else $error("byte delivered with an error status");

   // A refused channel reports nothing about any ring.
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mcrb_pkg::ST_BAD) |->
         (rsp_data.fill_count == '0) && (rsp_data.free_space == '0) &&
         (rsp_data.write_position == '0) && (rsp_data.read_position == '0))
      else $error("refused channel reports ring state");

endmodule

bind multi_channel_byte_ring_buffer mcrb_checker u_mcrb_checker (.*);
